// ===== hw/rtl/photoelectric_cross_section_unit_macros.svh =====
// Assertion macros used by the photoelectric cross section top module.
`ifndef PHOTOELECTRIC_CROSS_SECTION_UNIT_MACROS_SVH
`define PHOTOELECTRIC_CROSS_SECTION_UNIT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PCE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define PCE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/pce_pkg.sv =====
// Package: widths, breakpoint and coefficient tables, and the shared request type.
`timescale 1ns / 1ps
package pce_pkg;

  localparam int ENERGY_FRAC_BITS = 16;
  localparam int IN_W    = 20;
  localparam int OUT_W   = 32;
  localparam int SEG_W   = 4;
  localparam int NSEG    = 14;

  // breakpoints are held in thousandths of a keV
  localparam int BRK_W   = 14;
  localparam int MILLI_W = 10;
  localparam int THR_W   = (IN_W + MILLI_W > BRK_W + ENERGY_FRAC_BITS) ?
                           (IN_W + MILLI_W) : (BRK_W + ENERGY_FRAC_BITS);
  localparam logic [MILLI_W-1:0] MILLI_PER_KEV = MILLI_W'(1000);

  // coefficients are the fit values times 100, signed
  localparam int COEF_W = 19;
  localparam logic [6:0] COEF_SCALE = 7'd100;

  localparam int X2_W  = 2 * IN_W;
  localparam int X3_W  = 3 * IN_W;
  localparam int P1_W  = COEF_W + IN_W + 1;
  localparam int P2_W  = COEF_W + X2_W + 1;
  localparam int DEN_W = X3_W + 7;

  // numerator alignment: sigma * 2^16 = num / (100 * x^3)
  localparam int SH0 = 3 * ENERGY_FRAC_BITS + 16;
  localparam int SH1 = 2 * ENERGY_FRAC_BITS + 16;
  localparam int SH2 = ENERGY_FRAC_BITS + 16;

  localparam int NUM_A = 3 * ENERGY_FRAC_BITS + 33;
  localparam int NUM_B = ENERGY_FRAC_BITS + 74;
  localparam int NUM_W = ((NUM_A > NUM_B) ? NUM_A : NUM_B) + 2;
  localparam int CMP_W = (NUM_W > DEN_W + OUT_W) ? NUM_W : (DEN_W + OUT_W);

  // one overflow check stage plus one stage per quotient bit
  localparam int DSTAGES = OUT_W + 1;

  // request passed from the numerator front end to the divider
  typedef struct packed {
    logic [CMP_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic [SEG_W-1:0] seg;
  } pce_div_req_t;

  function automatic logic [BRK_W-1:0] brk_milli(input logic [SEG_W-1:0] s);
    logic [BRK_W-1:0] v;
    unique case (s)
      4'd0:    v = BRK_W'(100);
      4'd1:    v = BRK_W'(284);
      4'd2:    v = BRK_W'(400);
      4'd3:    v = BRK_W'(532);
      4'd4:    v = BRK_W'(707);
      4'd5:    v = BRK_W'(867);
      4'd6:    v = BRK_W'(1303);
      4'd7:    v = BRK_W'(1840);
      4'd8:    v = BRK_W'(2471);
      4'd9:    v = BRK_W'(3210);
      4'd10:   v = BRK_W'(4038);
      4'd11:   v = BRK_W'(7111);
      4'd12:   v = BRK_W'(8331);
      default: v = BRK_W'(10000);
    endcase
    return v;
  endfunction

  function automatic logic signed [COEF_W-1:0] coef_k0(input logic [SEG_W-1:0] s);
    logic signed [COEF_W-1:0] v;
    unique case (s)
      4'd0:    v = COEF_W'(1730);
      4'd1:    v = COEF_W'(3460);
      4'd2:    v = COEF_W'(7810);
      4'd3:    v = COEF_W'(7140);
      4'd4:    v = COEF_W'(9550);
      4'd5:    v = COEF_W'(30890);
      4'd6:    v = COEF_W'(12060);
      4'd7:    v = COEF_W'(14130);
      4'd8:    v = COEF_W'(20270);
      4'd9:    v = COEF_W'(34270);
      4'd10:   v = COEF_W'(35220);
      4'd11:   v = COEF_W'(43390);
      4'd12:   v = COEF_W'(62900);
      default: v = COEF_W'(70120);
    endcase
    return v;
  endfunction

  function automatic logic signed [COEF_W-1:0] coef_k1(input logic [SEG_W-1:0] s);
    logic signed [COEF_W-1:0] v;
    unique case (s)
      4'd0:    v = COEF_W'(60810);
      4'd1:    v = COEF_W'(26790);
      4'd2:    v = COEF_W'(1880);
      4'd3:    v = COEF_W'(6680);
      4'd4:    v = COEF_W'(14580);
      4'd5:    v = COEF_W'(-38060);
      4'd6:    v = COEF_W'(16930);
      4'd7:    v = COEF_W'(14680);
      4'd8:    v = COEF_W'(10470);
      4'd9:    v = COEF_W'(1870);
      4'd10:   v = COEF_W'(1870);
      4'd11:   v = COEF_W'(-240);
      4'd12:   v = COEF_W'(3090);
      default: v = COEF_W'(2520);
    endcase
    return v;
  endfunction

  function automatic logic signed [COEF_W-1:0] coef_k2(input logic [SEG_W-1:0] s);
    logic signed [COEF_W-1:0] v;
    unique case (s)
      4'd0:    v = COEF_W'(-215000);
      4'd1:    v = COEF_W'(-47610);
      4'd2:    v = COEF_W'(430);
      4'd3:    v = COEF_W'(-5140);
      4'd4:    v = COEF_W'(-6110);
      4'd5:    v = COEF_W'(29400);
      4'd6:    v = COEF_W'(-4770);
      4'd7:    v = COEF_W'(-3150);
      4'd8:    v = COEF_W'(-1700);
      4'd11:   v = COEF_W'(75);
      default: v = COEF_W'(0);
    endcase
    return v;
  endfunction

endpackage

// ===== hw/rtl/pce_front.sv =====
// Front end: segment search, polynomial products, numerator and divisor.
`timescale 1ns / 1ps
module pce_front import pce_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [IN_W-1:0]     in_energy_kev,
  output logic                req_valid,
  input  logic                req_ready,
  output pce_div_req_t        req
);

  // stage 1: segment and x^2
  logic                v1_r;
  logic [IN_W-1:0]     x1_r;
  logic [X2_W-1:0]     x2_r;
  logic [SEG_W-1:0]    seg1_r;
  logic [SEG_W-1:0]    seg_nxt;
  logic [THR_W-1:0]    milli;

  // stage 2: coefficient products and x^3
  logic                        v2_r;
  logic signed [COEF_W-1:0]    k0_r;
  logic signed [P1_W-1:0]      p1_r;
  logic signed [P2_W-1:0]      p2_r;
  logic [X3_W-1:0]             x3_r;
  logic [SEG_W-1:0]            seg2_r;
  logic signed [COEF_W-1:0]    k1_sel;
  logic signed [COEF_W-1:0]    k2_sel;
  logic signed [P1_W-1:0]      p1_nxt;
  logic signed [P2_W-1:0]      p2_nxt;

  // stage 3: aligned numerator and divisor
  logic                        v3_r;
  pce_div_req_t                req_r;
  logic signed [NUM_W-1:0]     num;
  pce_div_req_t                req_nxt;

  logic adv1, adv2, adv3;

  // advance a stage when it is empty or its successor takes its request
  assign adv3     = !v3_r || req_ready;
  assign adv2     = !v2_r || adv3;
  assign adv1     = !v1_r || adv2;
  assign in_stall = !adv1;

  // pick the first breakpoint above the energy; default to the last segment
  always_comb begin
    milli   = THR_W'(in_energy_kev) * THR_W'(MILLI_PER_KEV);
    seg_nxt = SEG_W'(NSEG - 1);
    for (int i = NSEG - 1; i >= 0; i--) begin
      if (milli < (THR_W'(brk_milli(SEG_W'(i))) << ENERGY_FRAC_BITS)) begin
        seg_nxt = SEG_W'(i);
      end
    end
  end

  // form the signed products for the selected segment
  always_comb begin
    k1_sel = coef_k1(seg1_r);
    k2_sel = coef_k2(seg1_r);
    p1_nxt = P1_W'(k1_sel) * P1_W'($signed({1'b0, x1_r}));
    p2_nxt = P2_W'(k2_sel) * P2_W'($signed({1'b0, x2_r}));
  end

  // sum the aligned terms; clamp a negative numerator to zero
  always_comb begin
    num = (NUM_W'(k0_r) <<< SH0) + (NUM_W'(p1_r) <<< SH1) + (NUM_W'(p2_r) <<< SH2);
    req_nxt.rem = num[NUM_W-1] ? '0 : CMP_W'($unsigned(num));
    req_nxt.den = DEN_W'(x3_r) * DEN_W'(COEF_SCALE);
    req_nxt.seg = seg2_r;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (adv1 && in_valid) begin
      x1_r   <= in_energy_kev;
      x2_r   <= X2_W'(in_energy_kev) * X2_W'(in_energy_kev);
      seg1_r <= seg_nxt;
    end
    if (adv2 && v1_r) begin
      k0_r   <= coef_k0(seg1_r);
      p1_r   <= p1_nxt;
      p2_r   <= p2_nxt;
      x3_r   <= X3_W'(x2_r) * X3_W'(x1_r);
      seg2_r <= seg1_r;
    end
    if (adv3 && v2_r) begin
      req_r <= req_nxt;
    end
  end

  assign req_valid = v3_r;
  assign req       = req_r;

endmodule

// ===== hw/rtl/pce_divider.sv =====
// Pipelined restoring divider: overflow check, then one quotient bit per stage.
`timescale 1ns / 1ps
module pce_divider import pce_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                req_valid,
  output logic                req_ready,
  input  pce_div_req_t        req,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [OUT_W-1:0]    out_cross_section,
  output logic [SEG_W-1:0]    out_segment,
  output logic                out_saturated
);

  logic               vld_r [DSTAGES];
  logic [CMP_W-1:0]   rem_r [DSTAGES];
  logic [DEN_W-1:0]   den_r [DSTAGES];
  logic [OUT_W-1:0]   quo_r [DSTAGES];
  logic [SEG_W-1:0]   seg_r [DSTAGES];
  logic               sat_r [DSTAGES];

  logic               src_vld [DSTAGES];
  logic [CMP_W-1:0]   src_rem [DSTAGES];
  logic [DEN_W-1:0]   src_den [DSTAGES];
  logic [OUT_W-1:0]   src_quo [DSTAGES];
  logic [SEG_W-1:0]   src_seg [DSTAGES];
  logic               src_sat [DSTAGES];

  logic [CMP_W:0]     diff    [DSTAGES];
  logic [CMP_W-1:0]   rem_nxt [DSTAGES];
  logic [OUT_W-1:0]   quo_nxt [DSTAGES];
  logic               sat_nxt [DSTAGES];
  logic               rdy     [DSTAGES+1];

  // feed each stage from the front end or from the stage before it
  always_comb begin
    for (int j = 0; j < DSTAGES; j++) begin
      if (j == 0) begin
        src_vld[j] = req_valid;
        src_rem[j] = req.rem;
        src_den[j] = req.den;
        src_quo[j] = '0;
        src_seg[j] = req.seg;
        src_sat[j] = 1'b0;
      end else begin
        src_vld[j] = vld_r[j-1];
        src_rem[j] = rem_r[j-1];
        src_den[j] = den_r[j-1];
        src_quo[j] = quo_r[j-1];
        src_seg[j] = seg_r[j-1];
        src_sat[j] = sat_r[j-1];
      end
    end
  end

  // trial subtract of the divisor shifted to this stage's bit
  always_comb begin
    for (int j = 0; j < DSTAGES; j++) begin
      diff[j] = {1'b0, src_rem[j]} - {1'b0, CMP_W'(src_den[j]) << (OUT_W - j)};
      if (j == 0) begin
        // quotient too large (or zero divisor): saturate, keep remainder
        sat_nxt[j] = !diff[j][CMP_W];
        quo_nxt[j] = diff[j][CMP_W] ? '0 : '1;
        rem_nxt[j] = src_rem[j];
      end else begin
        sat_nxt[j] = src_sat[j];
        if (!src_sat[j] && !diff[j][CMP_W]) begin
          quo_nxt[j] = src_quo[j] | (OUT_W'(1) << (OUT_W - j));
          rem_nxt[j] = diff[j][CMP_W-1:0];
        end else begin
          quo_nxt[j] = src_quo[j];
          rem_nxt[j] = src_rem[j];
        end
      end
    end
  end

  // ready chain: a stage takes a request when empty or when it moves on
  always_comb begin
    rdy[DSTAGES] = !out_stall;
    for (int j = DSTAGES - 1; j >= 0; j--) begin
      rdy[j] = !vld_r[j] || rdy[j+1];
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < DSTAGES; j++) vld_r[j] <= 1'b0;
    end else begin
      for (int j = 0; j < DSTAGES; j++) begin
        if (rdy[j]) vld_r[j] <= src_vld[j];
      end
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    for (int j = 0; j < DSTAGES; j++) begin
      if (rdy[j] && src_vld[j]) begin
        rem_r[j] <= rem_nxt[j];
        den_r[j] <= src_den[j];
        quo_r[j] <= quo_nxt[j];
        seg_r[j] <= src_seg[j];
        sat_r[j] <= sat_nxt[j];
      end
    end
  end

  assign req_ready         = rdy[0];
  assign out_valid         = vld_r[DSTAGES-1];
  assign out_cross_section = quo_r[DSTAGES-1];
  assign out_segment       = seg_r[DSTAGES-1];
  assign out_saturated     = sat_r[DSTAGES-1];

endmodule

// ===== hw/rtl/photoelectric_cross_section_unit.sv =====
// 3 front-end and 33 divider stages lie between request and result; valid bits ride along.
// One request per cycle while out_stall is low; every stage holds one request.
// The divider resolves one quotient bit per stage after a single overflow-check stage.
// A stalled output holds; upstream stages keep filling bubbles until the pipe is full.
// Reset (rst_n low, synchronous) clears all stage valid bits; payload is not reset.
`timescale 1ns / 1ps
`include "photoelectric_cross_section_unit_macros.svh"
module photoelectric_cross_section_unit import pce_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [IN_W-1:0]     in_energy_kev,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [OUT_W-1:0]    out_cross_section,
  output logic [SEG_W-1:0]    out_segment,
  output logic                out_saturated
);

  logic         req_valid;
  logic         req_ready;
  pce_div_req_t req;

  // numerator, divisor and segment
  pce_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_energy_kev (in_energy_kev),
    .req_valid     (req_valid),
    .req_ready     (req_ready),
    .req           (req)
  );

  // quotient and saturation
  pce_divider u_divider (
    .clk               (clk),
    .rst_n             (rst_n),
    .req_valid         (req_valid),
    .req_ready         (req_ready),
    .req               (req),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_cross_section (out_cross_section),
    .out_segment       (out_segment),
    .out_saturated     (out_saturated)
  );

  // a saturated result carries the full-scale value
  `PCE_ASSERT_NOW(a_sat_full_scale, out_valid && out_saturated, out_cross_section == '1, "saturated result not full scale")

  // an empty output stage means the whole pipe can take a request
  `PCE_ASSERT_NOW(a_empty_out_ready, !out_valid, !in_stall, "input stalled with empty output stage")

  // an unstalled output never backs up the input
  `PCE_ASSERT_NOW(a_flow_ready, !out_stall, !in_stall, "input stalled while output flows")

  // a valid result names a segment in range
  `PCE_ASSERT_NOW(a_segment_range, out_valid, out_segment <= SEG_W'(NSEG - 1), "segment out of range")

  // hold a stalled result unchanged
  `PCE_ASSERT_NEXT(a_stall_hold, out_valid && out_stall, out_valid && $stable(out_cross_section) && $stable(out_segment) && $stable(out_saturated), "stalled result changed")

endmodule

// ===== bench/tb_top.sv =====
// Testbench for photoelectric_cross_section_unit: predicted cross sections checked with and without idling.
`timescale 1ns / 1ps
module tb_top;
  import pce_pkg::*;

  // breakpoints in thousandths of a keV and fit coefficients times 100
  localparam int XS_BRK[NSEG] = '{100, 284, 400, 532, 707, 867, 1303, 1840, 2471,
                                  3210, 4038, 7111, 8331, 10000};
  localparam int XS_K0[NSEG] = '{1730, 3460, 7810, 7140, 9550, 30890, 12060, 14130,
                                 20270, 34270, 35220, 43390, 62900, 70120};
  localparam int XS_K1[NSEG] = '{60810, 26790, 1880, 6680, 14580, -38060, 16930,
                                 14680, 10470, 1870, 1870, -240, 3090, 2520};
  localparam int XS_K2[NSEG] = '{-215000, -47610, 430, -5140, -6110, 29400, -4770,
                                 -3150, -1700, 0, 0, 75, 0, 0};
  localparam int FB = ENERGY_FRAC_BITS;
  localparam int DRAIN_CYCLES = 60;

  typedef struct packed {
    logic [IN_W-1:0]  energy;
    logic [OUT_W-1:0] cross_section;
    logic [SEG_W-1:0] segment;
    logic             saturated;
  } xsec_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [IN_W-1:0]  in_energy_kev = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [OUT_W-1:0] out_cross_section;
  logic [SEG_W-1:0] out_segment;
  logic             out_saturated;

  xsec_t pending_xsec[$];
  xsec_t want;
  int    mismatches = 0;
  int    stall_left = 0;
  bit    idling_on = 1'b1;

  photoelectric_cross_section_unit i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_energy_kev     (in_energy_kev),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_cross_section (out_cross_section),
    .out_segment       (out_segment),
    .out_saturated     (out_saturated)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // first energy (keV, FB fraction bits) that falls at or above breakpoint i
  function automatic logic [IN_W-1:0] segment_floor(input int i);
    return IN_W'(((64'(XS_BRK[i]) << FB) + 999) / 1000);
  endfunction

  // sigma = (k0 + k1*E + k2*E^2) / E^3 as Q16.16, truncated, saturating
  function automatic xsec_t predict_xsec(input logic [IN_W-1:0] e);
    xsec_t             r;
    logic signed [129:0] num;
    logic [129:0]      den;
    logic [129:0]      quo;
    logic [63:0]       milli;
    int                s;
    s = NSEG - 1;
    milli = 64'(e) * 1000;
    for (int i = NSEG - 1; i >= 0; i--) begin
      if (milli < (64'(XS_BRK[i]) << FB)) s = i;
    end
    r.energy = e;
    r.segment = SEG_W'(s);
    if (e == '0) begin
      r.cross_section = '1;
      r.saturated = 1'b1;
      return r;
    end
    // numerator aligned so that the quotient by 100*E^3 lands in Q16.16
    num = (130'(XS_K0[s]) << (3 * FB + 16))
        + ((130'(XS_K1[s]) * 130'(e)) << (2 * FB + 16))
        + ((130'(XS_K2[s]) * 130'(e) * 130'(e)) << (FB + 16));
    if (num <= 0) begin
      r.cross_section = '0;
      r.saturated = 1'b0;
      return r;
    end
    den = 130'(e) * 130'(e) * 130'(e) * 130'(100);
    quo = $unsigned(num) / den;
    if (quo > 130'({OUT_W{1'b1}})) begin
      r.cross_section = '1;
      r.saturated = 1'b1;
    end else begin
      r.cross_section = quo[OUT_W-1:0];
      r.saturated = 1'b0;
    end
    return r;
  endfunction

  // mix of full range, the low-energy saturation region and breakpoint neighborhoods
  function automatic logic [IN_W-1:0] draw_energy();
    int      pick;
    longint  v;
    pick = $urandom_range(0, 3);
    case (pick)
      1: begin
        // below 0.12 keV the result crosses the saturation limit
        v = longint'($urandom_range(1, 8000));
      end
      2: begin
        v = longint'(segment_floor($urandom_range(0, NSEG - 1)))
          + longint'($urandom_range(0, 64)) - 32;
      end
      default: begin
        v = longint'($urandom_range(0, (1 << IN_W) - 1));
      end
    endcase
    return IN_W'(v);
  endfunction

  // send one request, then record its expected result once accepted
  task automatic send_energy(input logic [IN_W-1:0] e);
    int gap;
    gap = idling_on ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_energy_kev <= e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_xsec.push_back(predict_xsec(e));
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (pending_xsec.size() != 0) @(posedge clk);
  endtask

  // zero, smallest and largest energy, every segment boundary
  task automatic test_directed_corners();
    send_energy('0);
    send_energy(IN_W'(1));
    send_energy(IN_W'(2));
    send_energy('1);
    for (int i = 0; i < NSEG; i++) begin
      send_energy(segment_floor(i));
    end
    send_energy(IN_W'(segment_floor(0) - 1));
    send_energy(IN_W'(segment_floor(NSEG - 1) - 1));
  endtask

  task automatic test_random_spectrum(input int count);
    idling_on = 1'b1;
    repeat (count) send_energy(draw_energy());
  endtask

  // full rate on both sides
  task automatic test_back_to_back(input int count);
    idling_on = 1'b0;
    repeat (count) send_energy(draw_energy());
    idling_on = 1'b1;
  endtask

  // hold off the sender until the pipe has emptied between bursts
  task automatic test_drain_pauses(input int bursts, input int burst_len);
    repeat (bursts) begin
      repeat (burst_len) send_energy(draw_energy());
      wait_for_drain();
    end
  endtask

  // check each accepted result and advance the receiver stall pattern
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_xsec.size() == 0) begin
        $display("%0t: unexpected result cross_section %h segment %0d saturated %b",
                 $time, out_cross_section, out_segment, out_saturated);
        mismatches++;
      end else begin
        want = pending_xsec.pop_front();
        if (out_cross_section !== want.cross_section) begin
          $display("%0t: energy %h cross_section expected %h actual %h",
                   $time, want.energy, want.cross_section, out_cross_section);
          mismatches++;
        end
        if (out_segment !== want.segment) begin
          $display("%0t: energy %h segment expected %0d actual %0d",
                   $time, want.energy, want.segment, out_segment);
          mismatches++;
        end
        if (out_saturated !== want.saturated) begin
          $display("%0t: energy %h saturated expected %b actual %b",
                   $time, want.energy, want.saturated, out_saturated);
          mismatches++;
        end
      end
      stall_left = idling_on ? $urandom_range(0, 10) : 0;
    end else if (stall_left > 0) begin
      stall_left--;
    end
    out_stall <= (stall_left > 0);
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_corners();
    test_random_spectrum(1000);
    test_back_to_back(200);
    test_drain_pauses(13, 10);
    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS photoelectric_cross_section_unit");
    end else begin
      $display("FAIL photoelectric_cross_section_unit");
    end
    $finish;
  end

  // hang guard
  initial begin
    #5_000_000;
    $display("FAIL photoelectric_cross_section_unit");
    $finish;
  end

endmodule

// ===== photoelectric_cross_section_unit.f =====
+incdir+hw/rtl
hw/rtl/pce_pkg.sv
hw/rtl/pce_front.sv
hw/rtl/pce_divider.sv
hw/rtl/photoelectric_cross_section_unit.sv
bench/tb_top.sv
